>>> sv/acce_pkg.sv
// Package for the CD-ROM command engine: codes, microcode word and control store.
`timescale 1ns / 1ps
package acce_pkg;

   // Command operation codes.
   localparam logic [7:0] OP_TUR        = 8'h00;
   localparam logic [7:0] OP_REQ_SENSE  = 8'h03;
   localparam logic [7:0] OP_INQUIRY    = 8'h12;
   localparam logic [7:0] OP_READ_CAP   = 8'h25;
   localparam logic [7:0] OP_READ10     = 8'h28;
   localparam logic [7:0] OP_READ_TOC   = 8'h43;
   localparam logic [7:0] OP_GET_CONFIG = 8'h46;
   localparam logic [7:0] OP_EVENT      = 8'h4A;
   localparam logic [7:0] OP_READ12     = 8'hA8;

   // Sense keys and additional sense codes.
   localparam logic [3:0] SK_NONE        = 4'h0;
   localparam logic [3:0] SK_NOT_READY   = 4'h2;
   localparam logic [3:0] SK_ILLEGAL     = 4'h5;
   localparam logic [7:0] ASC_NONE       = 8'h00;
   localparam logic [7:0] ASC_NO_MEDIUM  = 8'h3A;
   localparam logic [7:0] ASC_LBA_RANGE  = 8'h21;
   localparam logic [7:0] ASC_BAD_OPCODE = 8'h20;

   // Profile codes.
   localparam logic [15:0] PROF_CD  = 16'h0008;
   localparam logic [15:0] PROF_DVD = 16'h0010;

   // Sector size; must be a power of two so that the sector math is a shift.
   localparam int          SECTOR_BYTES = 2048;
   localparam int          SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam logic [31:0] SECTOR_WORD  = 32'(SECTOR_BYTES);

   // Configuration register indexes.
   localparam logic CSR_MEDIA_LOADED = 1'b0;
   localparam logic CSR_MEDIA_BYTES  = 1'b1;

   // Response lengths.
   localparam logic [5:0] LEN_INQ   = 6'd36;
   localparam logic [5:0] LEN_RCAP  = 6'd8;
   localparam logic [5:0] LEN_SENSE = 6'd18;
   localparam logic [5:0] LEN_TOC0  = 6'd20;
   localparam logic [5:0] LEN_TOC1  = 6'd12;
   localparam logic [5:0] LEN_GCFG  = 6'd20;
   localparam logic [5:0] LEN_EVENT = 6'd8;

   // Control store addresses.
   localparam logic [7:0] PC_TUR       = 8'd0;
   localparam logic [7:0] PC_GOOD      = 8'd1;
   localparam logic [7:0] PC_NOMEDIA   = 8'd2;
   localparam logic [7:0] PC_BADOP     = 8'd3;
   localparam logic [7:0] PC_RANGE_ERR = 8'd4;
   localparam logic [7:0] PC_READ      = 8'd5;
   localparam logic [7:0] PC_INQ       = 8'd10;
   localparam logic [7:0] PC_RCAP      = 8'd46;
   localparam logic [7:0] PC_RSENSE    = 8'd55;
   localparam logic [7:0] PC_TOC       = 8'd73;
   localparam logic [7:0] PC_TOC0      = 8'd75;
   localparam logic [7:0] PC_TOC1      = 8'd95;
   localparam logic [7:0] PC_GCFG      = 8'd107;
   localparam logic [7:0] PC_EVENT     = 8'd128;

   localparam logic [7:0] INQUIRY_DATA [36] = '{
      8'h05, 8'h80, 8'h00, 8'h02, 8'd31, 8'h00, 8'h00, 8'h00,
      8'h48, 8'h59, 8'h50, 8'h45, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h56, 8'h49, 8'h52, 8'h54, 8'h55, 8'h41, 8'h4C, 8'h20,
      8'h43, 8'h44, 8'h2D, 8'h52, 8'h4F, 8'h4D, 8'h20, 8'h20,
      8'h31, 8'h2E, 8'h30, 8'h20
   };

   typedef enum logic [2:0] {
      JC_NONE, JC_NO_MEDIA, JC_ZERO_COUNT, JC_RANGE_BAD, JC_TOC1
   } jcond_type;

   typedef enum logic [1:0] {EM_NONE, EM_BYTE, EM_SINGLE} emit_type;

   typedef enum logic [2:0] {
      BS_CONST, BS_SENSE_KEY, BS_ASC, BS_LAST_LBA, BS_SECTOR, BS_TOTAL, BS_EVENT
   } bsel_type;

   typedef enum logic [2:0] {
      SA_KEEP, SA_CLEAR, SA_NO_MEDIUM, SA_RANGE, SA_OPCODE
   } sense_type;

   typedef struct packed {
      jcond_type  jc;
      logic [7:0] target;
      emit_type   emit;
      bsel_type   bsel;
      logic [1:0] bidx;    // byte of a 32-bit word, 0 is the most significant
      logic [7:0] cbyte;
      logic [5:0] rlen;
      logic       status;
      logic       media;
      sense_type  sense;
      logic       calc;    // load the remaining-sector difference
      logic       last;    // final step of the program
   } uword_type;

   function automatic uword_type uw_nop();
      uword_type w;
      w.jc     = JC_NONE;
      w.target = 8'd0;
      w.emit   = EM_NONE;
      w.bsel   = BS_CONST;
      w.bidx   = 2'd0;
      w.cbyte  = 8'd0;
      w.rlen   = 6'd0;
      w.status = 1'b0;
      w.media  = 1'b0;
      w.sense  = SA_KEEP;
      w.calc   = 1'b0;
      w.last   = 1'b0;
      return w;
   endfunction

   function automatic uword_type uw_jump(input jcond_type c, input logic [7:0] t,
                                         input sense_type s);
      uword_type w;
      w        = uw_nop();
      w.jc     = c;
      w.target = t;
      w.sense  = s;
      return w;
   endfunction

   function automatic uword_type uw_single(input logic st, input logic md,
                                           input sense_type s);
      uword_type w;
      w        = uw_nop();
      w.emit   = EM_SINGLE;
      w.status = st;
      w.media  = md;
      w.sense  = s;
      w.last   = 1'b1;
      return w;
   endfunction

   function automatic uword_type uw_const(input logic [7:0] b, input logic [5:0] len,
                                          input logic lst);
      uword_type w;
      w       = uw_nop();
      w.emit  = EM_BYTE;
      w.cbyte = b;
      w.rlen  = len;
      w.last  = lst;
      return w;
   endfunction

   function automatic uword_type uw_sel(input bsel_type bs, input logic [1:0] idx,
                                        input logic [5:0] len, input logic lst);
      uword_type w;
      w      = uw_const(8'd0, len, lst);
      w.bsel = bs;
      w.bidx = idx;
      return w;
   endfunction

   // Dispatch table: opcode to program entry.
   function automatic logic [7:0] ucode_entry(input logic [7:0] op);
      logic [7:0] pc;
      case (op)
         OP_TUR:                pc = PC_TUR;
         OP_REQ_SENSE:          pc = PC_RSENSE;
         OP_INQUIRY:            pc = PC_INQ;
         OP_READ_CAP:           pc = PC_RCAP;
         OP_READ10, OP_READ12:  pc = PC_READ;
         OP_READ_TOC:           pc = PC_TOC;
         OP_GET_CONFIG:         pc = PC_GCFG;
         OP_EVENT:              pc = PC_EVENT;
         default:               pc = PC_BADOP;
      endcase
      return pc;
   endfunction

   // Control store. Specific entries come before the zero-byte ranges of a stream.
   function automatic uword_type ucode_rom(input logic [7:0] pc);
      uword_type w;
      w = uw_nop();
      case (pc) inside
         PC_TUR:       w = uw_jump(JC_NO_MEDIA, PC_NOMEDIA, SA_CLEAR);
         PC_GOOD:      w = uw_single(1'b0, 1'b0, SA_CLEAR);
         PC_NOMEDIA:   w = uw_single(1'b1, 1'b0, SA_NO_MEDIUM);
         PC_BADOP:     w = uw_single(1'b1, 1'b0, SA_OPCODE);
         PC_RANGE_ERR: w = uw_single(1'b1, 1'b0, SA_RANGE);

         // Reads: media, zero count, remaining sectors, range, transfer.
         PC_READ:         w = uw_jump(JC_NO_MEDIA, PC_NOMEDIA, SA_KEEP);
         PC_READ + 8'd1:  w = uw_jump(JC_ZERO_COUNT, PC_GOOD, SA_KEEP);
         PC_READ + 8'd2:  begin
            w      = uw_nop();
            w.calc = 1'b1;
         end
         PC_READ + 8'd3:  w = uw_jump(JC_RANGE_BAD, PC_RANGE_ERR, SA_KEEP);
         PC_READ + 8'd4:  w = uw_single(1'b0, 1'b1, SA_CLEAR);

         PC_INQ: begin
            w       = uw_const(INQUIRY_DATA[0], LEN_INQ, 1'b0);
            w.sense = SA_CLEAR;
         end
         PC_INQ + 8'd35: w = uw_const(INQUIRY_DATA[35], LEN_INQ, 1'b1);
         [PC_INQ + 8'd1 : PC_INQ + 8'd34]:
            w = uw_const(INQUIRY_DATA[6'(pc - PC_INQ)], LEN_INQ, 1'b0);

         PC_RCAP:        w = uw_jump(JC_NO_MEDIA, PC_NOMEDIA, SA_CLEAR);
         [PC_RCAP + 8'd1 : PC_RCAP + 8'd4]:
            w = uw_sel(BS_LAST_LBA, 2'(pc - PC_RCAP - 8'd1), LEN_RCAP, 1'b0);
         [PC_RCAP + 8'd5 : PC_RCAP + 8'd7]:
            w = uw_sel(BS_SECTOR, 2'(pc - PC_RCAP - 8'd5), LEN_RCAP, 1'b0);
         PC_RCAP + 8'd8: w = uw_sel(BS_SECTOR, 2'd3, LEN_RCAP, 1'b1);

         PC_RSENSE:          w = uw_const(8'h70, LEN_SENSE, 1'b0);
         PC_RSENSE + 8'd2:   w = uw_sel(BS_SENSE_KEY, 2'd0, LEN_SENSE, 1'b0);
         PC_RSENSE + 8'd7:   w = uw_const(8'd10, LEN_SENSE, 1'b0);
         PC_RSENSE + 8'd12:  w = uw_sel(BS_ASC, 2'd0, LEN_SENSE, 1'b0);
         PC_RSENSE + 8'd17:  w = uw_const(8'h00, LEN_SENSE, 1'b1);
         [PC_RSENSE + 8'd1 : PC_RSENSE + 8'd16]:
            w = uw_const(8'h00, LEN_SENSE, 1'b0);

         PC_TOC:          w = uw_jump(JC_NO_MEDIA, PC_NOMEDIA, SA_CLEAR);
         PC_TOC + 8'd1:   w = uw_jump(JC_TOC1, PC_TOC1, SA_KEEP);

         // TOC format 0: header, track 1 and lead-out descriptors.
         PC_TOC0 + 8'd1:  w = uw_const(8'd18, LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd2:  w = uw_const(8'h01, LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd3:  w = uw_const(8'h01, LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd5:  w = uw_const(8'h14, LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd6:  w = uw_const(8'h01, LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd13: w = uw_const(8'h14, LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd14: w = uw_const(8'hAA, LEN_TOC0, 1'b0);
         [PC_TOC0 + 8'd16 : PC_TOC0 + 8'd18]:
            w = uw_sel(BS_TOTAL, 2'(pc - PC_TOC0 - 8'd16), LEN_TOC0, 1'b0);
         PC_TOC0 + 8'd19: w = uw_sel(BS_TOTAL, 2'd3, LEN_TOC0, 1'b1);
         [PC_TOC0 : PC_TOC0 + 8'd15]:
            w = uw_const(8'h00, LEN_TOC0, 1'b0);

         // TOC format 1: session information.
         PC_TOC1 + 8'd1:  w = uw_const(8'd10, LEN_TOC1, 1'b0);
         PC_TOC1 + 8'd2:  w = uw_const(8'h01, LEN_TOC1, 1'b0);
         PC_TOC1 + 8'd3:  w = uw_const(8'h01, LEN_TOC1, 1'b0);
         PC_TOC1 + 8'd5:  w = uw_const(8'h14, LEN_TOC1, 1'b0);
         PC_TOC1 + 8'd6:  w = uw_const(8'h01, LEN_TOC1, 1'b0);
         PC_TOC1 + 8'd11: w = uw_const(8'h00, LEN_TOC1, 1'b1);
         [PC_TOC1 : PC_TOC1 + 8'd10]:
            w = uw_const(8'h00, LEN_TOC1, 1'b0);

         PC_GCFG:          w = uw_jump(JC_NO_MEDIA, PC_NOMEDIA, SA_CLEAR);
         PC_GCFG + 8'd4:   w = uw_const(8'd16, LEN_GCFG, 1'b0);
         PC_GCFG + 8'd7:   w = uw_const(PROF_DVD[15:8], LEN_GCFG, 1'b0);
         PC_GCFG + 8'd8:   w = uw_const(PROF_DVD[7:0], LEN_GCFG, 1'b0);
         PC_GCFG + 8'd11:  w = uw_const(8'h03, LEN_GCFG, 1'b0);
         PC_GCFG + 8'd12:  w = uw_const(8'd8, LEN_GCFG, 1'b0);
         PC_GCFG + 8'd13:  w = uw_const(PROF_CD[15:8], LEN_GCFG, 1'b0);
         PC_GCFG + 8'd14:  w = uw_const(PROF_CD[7:0], LEN_GCFG, 1'b0);
         PC_GCFG + 8'd17:  w = uw_const(PROF_DVD[15:8], LEN_GCFG, 1'b0);
         PC_GCFG + 8'd18:  w = uw_const(PROF_DVD[7:0], LEN_GCFG, 1'b0);
         PC_GCFG + 8'd19:  w = uw_const(8'h01, LEN_GCFG, 1'b0);
         PC_GCFG + 8'd20:  w = uw_const(8'h00, LEN_GCFG, 1'b1);
         [PC_GCFG + 8'd1 : PC_GCFG + 8'd16]:
            w = uw_const(8'h00, LEN_GCFG, 1'b0);

         PC_EVENT: begin
            w       = uw_const(8'h00, LEN_EVENT, 1'b0);
            w.sense = SA_CLEAR;
         end
         PC_EVENT + 8'd1: w = uw_const(8'd6, LEN_EVENT, 1'b0);
         PC_EVENT + 8'd2: w = uw_const(8'h04, LEN_EVENT, 1'b0);
         PC_EVENT + 8'd3: w = uw_const(8'h10, LEN_EVENT, 1'b0);
         PC_EVENT + 8'd5: w = uw_sel(BS_EVENT, 2'd0, LEN_EVENT, 1'b0);
         PC_EVENT + 8'd7: w = uw_const(8'h00, LEN_EVENT, 1'b1);
         [PC_EVENT + 8'd4 : PC_EVENT + 8'd6]:
            w = uw_const(8'h00, LEN_EVENT, 1'b0);

         default: w = uw_single(1'b1, 1'b0, SA_OPCODE);
      endcase
      return w;
   endfunction

endpackage

>>> sv/atapi_cdrom_command_engine.sv
// Top level of the CD-ROM command engine: microcode sequencer and datapath.
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// req       start / busy         req_opcode, req_cdb_b2 .. req_cdb_b9
// rsp       rsp_strobe           rsp_cmd_status .. rsp_last, one transaction per cycle
// csr       csr_we               csr_index, csr_wdata
//
// A command is taken when start is high and busy is low; busy then stays high while one
// microcode step runs per cycle. A streamed response of N bytes takes N steps (N + 1 with
// the media check, N + 2 for READ TOC), a read two to five steps, other commands one or two.
// Each result is registered and appears in the cycle after its step, and the next command can
// be taken in the cycle after the last step.
// Reset clears the sense data, configuration and sequencer; the receiver cannot stall.
module atapi_cdrom_command_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_cdb_b2,
   input  logic [7:0]  req_cdb_b3,
   input  logic [7:0]  req_cdb_b4,
   input  logic [7:0]  req_cdb_b5,
   input  logic [7:0]  req_cdb_b6,
   input  logic [7:0]  req_cdb_b7,
   input  logic [7:0]  req_cdb_b8,
   input  logic [7:0]  req_cdb_b9,
   output logic        rsp_strobe,
   output logic        rsp_cmd_status,
   output logic        rsp_uses_media,
   output logic [31:0] rsp_media_offset,
   output logic [31:0] rsp_media_length,
   output logic [5:0]  rsp_response_length,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import acce_pkg::*;

   logic        busy_ff, busy_in;
   logic [7:0]  pc_ff, pc_in;
   logic [31:0] lba_ff, lba_in;
   logic [31:0] count_ff, count_in;
   logic        toc1_ff, toc1_in;
   logic [31:0] rem_ff, rem_in;
   logic        lba_ge_ff, lba_ge_in;
   logic [3:0]  sense_key_ff, sense_key_in;
   logic [7:0]  asc_ff, asc_in;
   logic        media_loaded_ff;
   logic [31:0] media_bytes_ff;

   logic        strobe_ff, strobe_in;
   logic        status_ff, status_in;
   logic        uses_media_ff, uses_media_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] length_ff, length_in;
   logic [5:0]  rlen_ff, rlen_in;
   logic        dvalid_ff, dvalid_in;
   logic [7:0]  dbyte_ff, dbyte_in;
   logic        last_ff, last_in;

   uword_type   uw;
   logic        have_media;
   logic [31:0] total;
   logic [31:0] word;
   logic [7:0]  sel_byte;
   logic        jump_taken;

   assign uw         = ucode_rom(pc_ff);
   assign have_media = media_loaded_ff && (media_bytes_ff != 32'd0);
   assign total      = media_bytes_ff >> SECTOR_SHIFT;

   always_comb begin
      case (uw.jc)
         JC_NONE:       jump_taken = 1'b0;
         JC_NO_MEDIA:   jump_taken = !have_media;
         JC_ZERO_COUNT: jump_taken = (count_ff == 32'd0);
         JC_RANGE_BAD:  jump_taken = lba_ge_ff || (count_ff > rem_ff);
         JC_TOC1:       jump_taken = toc1_ff;
         default:       jump_taken = 1'b0;
      endcase
   end

   // Byte source for streamed responses.
   always_comb begin
      case (uw.bsel)
         BS_LAST_LBA: word = total - 32'd1;
         BS_SECTOR:   word = SECTOR_WORD;
         BS_TOTAL:    word = total;
         default:     word = 32'd0;
      endcase
      case (uw.bsel)
         BS_CONST:     sel_byte = uw.cbyte;
         BS_SENSE_KEY: sel_byte = {4'd0, sense_key_ff};
         BS_ASC:       sel_byte = asc_ff;
         BS_EVENT:     sel_byte = have_media ? 8'h02 : 8'h00;
         default: begin
            case (uw.bidx)
               2'd0:    sel_byte = word[31:24];
               2'd1:    sel_byte = word[23:16];
               2'd2:    sel_byte = word[15:8];
               default: sel_byte = word[7:0];
            endcase
         end
      endcase
   end

   // Sequencer and command latches.
   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      lba_in   = lba_ff;
      count_in = count_ff;
      toc1_in  = toc1_ff;
      if (busy_ff) begin
         pc_in = jump_taken ? uw.target : pc_ff + 8'd1;
         if (uw.last) begin
            busy_in = 1'b0;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         pc_in    = ucode_entry(req_opcode);
         lba_in   = {req_cdb_b2, req_cdb_b3, req_cdb_b4, req_cdb_b5};
         count_in = (req_opcode == OP_READ12) ?
                    {req_cdb_b6, req_cdb_b7, req_cdb_b8, req_cdb_b9} :
                    {16'd0, req_cdb_b7, req_cdb_b8};
         toc1_in  = (req_cdb_b2[3:0] == 4'd1);
      end
   end

   always_comb begin
      rem_in    = rem_ff;
      lba_ge_in = lba_ge_ff;
      if (busy_ff && uw.calc) begin
         rem_in    = total - lba_ff;
         lba_ge_in = (lba_ff >= total);
      end
   end

   always_comb begin
      sense_key_in = sense_key_ff;
      asc_in       = asc_ff;
      if (busy_ff) begin
         case (uw.sense)
            SA_KEEP: begin
               sense_key_in = sense_key_ff;
               asc_in       = asc_ff;
            end
            SA_CLEAR: begin
               sense_key_in = SK_NONE;
               asc_in       = ASC_NONE;
            end
            SA_NO_MEDIUM: begin
               sense_key_in = SK_NOT_READY;
               asc_in       = ASC_NO_MEDIUM;
            end
            SA_RANGE: begin
               sense_key_in = SK_ILLEGAL;
               asc_in       = ASC_LBA_RANGE;
            end
            SA_OPCODE: begin
               sense_key_in = SK_ILLEGAL;
               asc_in       = ASC_BAD_OPCODE;
            end
            default: begin
               sense_key_in = sense_key_ff;
               asc_in       = asc_ff;
            end
         endcase
      end
   end

   // Result register contents for the current step.
   always_comb begin
      strobe_in     = busy_ff && (uw.emit != EM_NONE);
      status_in     = 1'b0;
      uses_media_in = 1'b0;
      offset_in     = 32'd0;
      length_in     = 32'd0;
      rlen_in       = 6'd0;
      dvalid_in     = 1'b0;
      dbyte_in      = 8'd0;
      last_in       = uw.last;
      case (uw.emit)
         EM_BYTE: begin
            rlen_in   = uw.rlen;
            dvalid_in = 1'b1;
            dbyte_in  = sel_byte;
         end
         EM_SINGLE: begin
            status_in     = uw.status;
            uses_media_in = uw.media;
            if (uw.media) begin
               offset_in = lba_ff << SECTOR_SHIFT;
               length_in = count_ff << SECTOR_SHIFT;
            end
         end
         default: begin
            last_in = uw.last;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         pc_ff           <= PC_TUR;
         sense_key_ff    <= SK_NONE;
         asc_ff          <= ASC_NONE;
         media_loaded_ff <= 1'b0;
         media_bytes_ff  <= 32'd0;
         strobe_ff       <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         sense_key_ff <= sense_key_in;
         asc_ff       <= asc_in;
         strobe_ff    <= strobe_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MEDIA_LOADED: media_loaded_ff <= csr_wdata[0];
               CSR_MEDIA_BYTES:  media_bytes_ff  <= csr_wdata;
               default:          media_bytes_ff  <= media_bytes_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lba_ff        <= lba_in;
      count_ff      <= count_in;
      toc1_ff       <= toc1_in;
      rem_ff        <= rem_in;
      lba_ge_ff     <= lba_ge_in;
      status_ff     <= status_in;
      uses_media_ff <= uses_media_in;
      offset_ff     <= offset_in;
      length_ff     <= length_in;
      rlen_ff       <= rlen_in;
      dvalid_ff     <= dvalid_in;
      dbyte_ff      <= dbyte_in;
      last_ff       <= last_in;
   end

   assign busy                = busy_ff;
   assign rsp_strobe          = strobe_ff;
   assign rsp_cmd_status      = status_ff;
   assign rsp_uses_media      = uses_media_ff;
   assign rsp_media_offset    = offset_ff;
   assign rsp_media_length    = length_ff;
   assign rsp_response_length = rlen_ff;
   assign rsp_data_valid      = dvalid_ff;
   assign rsp_data_byte       = dbyte_ff;
   assign rsp_last            = last_ff;

endmodule

>>> sv/acce_checker.sv
// Port-level checker for the CD-ROM command engine, with its bind statement.
`timescale 1ns / 1ps
module acce_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_cmd_status,
   input logic        rsp_uses_media,
   input logic [31:0] rsp_media_length,
   input logic [5:0]  rsp_response_length,
   input logic        rsp_data_valid,
   input logic        rsp_last
);

   // A streamed response has no gaps between its bytes.
   a_stream_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("response stream broke before its last byte");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // Results come only from a command that was in progress.
   a_result_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a command in progress");

   a_byte_no_media: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data_valid |-> !rsp_uses_media && rsp_media_length == 32'd0)
      else $error("response byte carries a media transfer");

   a_media_good: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_uses_media |-> !rsp_cmd_status && rsp_response_length == 6'd0
                                       && rsp_last)
      else $error("media transfer with bad status or response bytes");

endmodule

bind atapi_cdrom_command_engine acce_checker u_acce_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_cmd_status      (rsp_cmd_status),
   .rsp_uses_media      (rsp_uses_media),
   .rsp_media_length    (rsp_media_length),
   .rsp_response_length (rsp_response_length),
   .rsp_data_valid      (rsp_data_valid),
   .rsp_last            (rsp_last)
);
